@@ hw/rtl/tds_pkg.sv @@
`timescale 1ns / 1ps
package tds_pkg;

  localparam int unsigned DIGITS = 4;
  localparam int unsigned DIG_W  = $clog2(DIGITS);

  typedef logic [DIG_W-1:0] dig_idx_t;

  localparam dig_idx_t DIG_FRAC  = 2'd0;
  localparam dig_idx_t DIG_UNITS = 2'd1;
  localparam dig_idx_t DIG_TENS  = 2'd2;
  localparam dig_idx_t DIG_HUND  = 2'd3;

  localparam logic REG_TICKS     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [7:0] TICKS_RESET     = 8'd200;
  localparam logic [6:0] THRESHOLD_RESET = 7'd35;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [7:0] SEG_MINUS = 8'hbf;
  localparam logic [7:0] SEG_POINT = 8'h7f;
  localparam logic [7:0] NEG_LIMIT = 8'h80;

  localparam logic [3:0] SEL_FRAC  = 4'he;
  localparam logic [3:0] SEL_UNITS = 4'hd;
  localparam logic [3:0] SEL_TENS  = 4'hb;
  localparam logic [3:0] SEL_HUND  = 4'h7;

  typedef struct packed {
    logic [7:0] latched_integer;
    logic [3:0] shown_fraction;
    logic [6:0] shown_magnitude;
  } disp_t;

  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'hc0;
      4'd1:    p = 8'hf9;
      4'd2:    p = 8'ha4;
      4'd3:    p = 8'hb0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hf8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] digit_select(input dig_idx_t idx);
    logic [3:0] s;
    unique case (idx)
      DIG_FRAC:  s = SEL_FRAC;
      DIG_UNITS: s = SEL_UNITS;
      DIG_TENS:  s = SEL_TENS;
      default:   s = SEL_HUND;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/tds_digit_decode.sv @@
`timescale 1ns / 1ps
module tds_digit_decode (
  input  tds_pkg::dig_idx_t idx,
  input  tds_pkg::disp_t    disp,
  output logic [7:0]        segment_pattern
);
  import tds_pkg::*;

  logic [14:0] mag_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;
  logic [7:0]  frac_x10;
  logic        mag_small;
  logic        neg;

  // mag / 10 by reciprocal, exact for 7-bit magnitudes
  assign mag_prod  = 15'(disp.shown_magnitude) * 15'd205;
  assign tens      = mag_prod[14:11];
  assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign units     = 4'(disp.shown_magnitude - tens_x10);
  assign frac_x10  = 8'({disp.shown_fraction, 3'b000}) + 8'({disp.shown_fraction, 1'b0});
  assign mag_small = disp.shown_magnitude < 7'd10;
  assign neg       = disp.latched_integer > NEG_LIMIT;

  always_comb begin
    segment_pattern = SEG_BLANK;
    unique case (idx)
      DIG_FRAC: begin
        segment_pattern = digit_pattern(frac_x10[7:4]);
      end
      DIG_UNITS: begin
        segment_pattern = SEG_POINT & digit_pattern(units);
      end
      DIG_TENS: begin
        priority if (mag_small && disp.latched_integer < NEG_LIMIT) begin
          segment_pattern = SEG_BLANK;
        end else if (mag_small && neg) begin
          segment_pattern = SEG_MINUS;
        end else begin
          segment_pattern = digit_pattern(tens);
        end
      end
      default: begin
        segment_pattern = (neg && !mag_small) ? SEG_MINUS : SEG_BLANK;
      end
    endcase
  end

endmodule

@@ hw/rtl/temperature_display_scanner_core.sv @@
`timescale 1ns / 1ps
// Four-digit multiplexed temperature display scanner. Each input beat is one
// scan tick carrying the sensor reading; every tick yields one output beat
// with the segment pattern and active-low digit select for the next digit in
// turn (fraction, units with point, tens, sign) plus the relay level. A new
// reading is latched every ticks_per_reading ticks and is shown on that same
// tick. One beat per cycle is sustained while out_tready is high: one output
// register holds the result; input is taken whenever it is empty or drained.
module temperature_display_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reading_integer[7:0], reading_fraction[11:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // segment_pattern[7:0], digit_enable[11:8], relay_level[12]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import tds_pkg::*;

  logic [7:0] ticks_per_reading_r;
  logic [6:0] relay_threshold_r;
  logic [7:0] tick_count_r, tick_count_nxt;
  dig_idx_t   digit_index_r;
  disp_t      disp_r, disp_nxt;
  logic       out_valid_r;
  logic [15:0] out_data_r, out_data_nxt;

  logic       accept;
  logic [7:0] tick_inc;
  logic       latch;
  logic [7:0] rd_int;
  logic [3:0] rd_frac;
  logic [7:0] seg;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_int   = in_tdata[7:0];
  assign rd_frac  = in_tdata[11:8];
  assign tick_inc = tick_count_r + 8'd1;
  assign latch    = tick_inc >= ticks_per_reading_r;

  always_comb begin
    tick_count_nxt = latch ? 8'd0 : tick_inc;
    disp_nxt       = disp_r;
    if (latch) begin
      disp_nxt.latched_integer = rd_int;
      if (rd_int[7]) begin
        disp_nxt.shown_magnitude = 7'(~rd_int) + 7'(rd_frac == 4'd0);
        disp_nxt.shown_fraction  = 4'(~rd_frac) + 4'd1;
      end else begin
        disp_nxt.shown_magnitude = rd_int[6:0];
        disp_nxt.shown_fraction  = rd_frac;
      end
    end
  end

  tds_digit_decode u_decode (
    .idx             (digit_index_r),
    .disp            (disp_nxt),
    .segment_pattern (seg)
  );

  assign out_data_nxt = {3'b000,
                         (disp_nxt.shown_magnitude >= relay_threshold_r) ? 1'b0 : 1'b1,
                         digit_select(digit_index_r),
                         seg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_reading_r <= TICKS_RESET;
      relay_threshold_r   <= THRESHOLD_RESET;
      tick_count_r        <= '0;
      digit_index_r       <= DIG_FRAC;
      disp_r              <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICKS:     ticks_per_reading_r <= cfg_wdata;
          default:       relay_threshold_r   <= cfg_wdata[6:0];
        endcase
      end
      if (accept) begin
        tick_count_r  <= tick_count_nxt;
        digit_index_r <= digit_index_r + dig_idx_t'(1);
        disp_r        <= disp_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
